>>> rtl/pcms_pkg.sv
`default_nettype none

package pcms_pkg;

	localparam int unsigned DEF_MAX_WINDOW  = 256;
	localparam int unsigned DEF_SAMPLE_BITS = 12;

	localparam int unsigned WLEN_W    = 9;
	localparam int unsigned GAIN_W    = 24;
	localparam int unsigned CFG_W     = 24;
	localparam int unsigned CFG_IDX_W = 2;

	localparam int unsigned CUR_OW   = 32;
	localparam int unsigned SLOPE_OW = 48;
	localparam int unsigned BUS_OW   = 32;

	// The first product is kept to 64 bits; the second multiplier is twice the rate.
	localparam int unsigned PROD1_W = 64;
	localparam int unsigned MPL_W   = GAIN_W + 1;
	localparam int unsigned DW      = PROD1_W + MPL_W;
	localparam int unsigned STEP_W  = $clog2(DW);

	localparam logic [WLEN_W-1:0] WLEN_RST = WLEN_W'(8);
	localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(65536);
	localparam logic [GAIN_W-1:0] RATE_RST = GAIN_W'(1000000);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_LEN   = 2'd0,
		REG_CURRENT_GAIN = 2'd1,
		REG_VBUS_GAIN    = 2'd2,
		REG_SAMPLE_RATE  = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		JOB_CUR_U = 3'd0,
		JOB_CUR_V = 3'd1,
		JOB_CUR_W = 3'd2,
		JOB_SLP_U = 3'd3,
		JOB_SLP_V = 3'd4,
		JOB_SLP_W = 3'd5,
		JOB_BUS   = 3'd6
	} job_t;

	typedef struct packed {
		logic acc;
		logic clear;
		logic mul_load;
		logic mul_step;
		logic mul2_load;
		logic div_step;
		logic store;
		job_t job;
	} cmd_t;

	typedef struct packed {
		logic last;
	} sts_t;

endpackage

`default_nettype wire

>>> rtl/pcms_ctrl.sv
`default_nettype none

module pcms_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  wire logic           out_stall,
	input  wire pcms_pkg::sts_t sts,
	output pcms_pkg::cmd_t      cmd
);
	import pcms_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_WAIT   = 8'b0000_0010,
		S_LOAD   = 8'b0000_0100,
		S_MUL    = 8'b0000_1000,
		S_RELOAD = 8'b0001_0000,
		S_MUL2   = 8'b0010_0000,
		S_DIV    = 8'b0100_0000,
		S_STORE  = 8'b1000_0000
	} state_t;

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	job_t              job_q, job_d;
	logic              out_valid_q, out_valid_d;
	logic              is_slope;

	assign is_slope  = job_q inside {JOB_SLP_U, JOB_SLP_V, JOB_SLP_W};
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.job     = job_q;
		state_d     = state_q;
		step_d      = step_q;
		job_d       = job_q;
		out_valid_d = out_valid_q;
		if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end
		case (state_q)
			S_IDLE: begin
				job_d = JOB_CUR_U;
				if (in_valid) begin
					cmd.acc = 1'b1;
					if (sts.last) begin
						state_d = S_WAIT;
					end
				end
			end
			S_WAIT: begin
				if (!out_valid_q) begin
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.mul_load = 1'b1;
				step_d       = '0;
				state_d      = S_MUL;
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				step_d       = step_q + STEP_W'(1);
				if (step_q == STEP_W'(GAIN_W - 1)) begin
					step_d  = '0;
					state_d = is_slope ? S_RELOAD : S_DIV;
				end
			end
			S_RELOAD: begin
				cmd.mul2_load = 1'b1;
				step_d        = '0;
				state_d       = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul_step = 1'b1;
				step_d       = step_q + STEP_W'(1);
				if (step_q == STEP_W'(MPL_W - 1)) begin
					step_d  = '0;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				step_d       = step_q + STEP_W'(1);
				if (step_q == STEP_W'(DW - 1)) begin
					step_d  = '0;
					state_d = S_STORE;
				end
			end
			S_STORE: begin
				cmd.store = 1'b1;
				if (job_q == JOB_BUS) begin
					cmd.clear   = 1'b1;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end else begin
					job_d   = job_t'(3'(job_q + 3'd1));
					state_d = S_LOAD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			job_q       <= JOB_CUR_U;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			step_q      <= step_d;
			job_q       <= job_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/pcms_dpath.sv
`default_nettype none

module pcms_dpath #(
	parameter int unsigned MAX_WINDOW  = pcms_pkg::DEF_MAX_WINDOW,
	parameter int unsigned SAMPLE_BITS = pcms_pkg::DEF_SAMPLE_BITS
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [pcms_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [pcms_pkg::CFG_W-1:0]           cfg_data,
	input  wire logic [SAMPLE_BITS-1:0]               u_raw,
	input  wire logic [SAMPLE_BITS-1:0]               v_raw,
	input  wire logic [SAMPLE_BITS-1:0]               w_raw,
	input  wire logic [SAMPLE_BITS-1:0]               bus_raw,
	input  wire pcms_pkg::cmd_t                       cmd,
	output pcms_pkg::sts_t                            sts,
	output logic signed [pcms_pkg::CUR_OW-1:0]        current_u,
	output logic signed [pcms_pkg::CUR_OW-1:0]        current_v,
	output logic signed [pcms_pkg::CUR_OW-1:0]        current_w,
	output logic signed [pcms_pkg::SLOPE_OW-1:0]      slope_u,
	output logic signed [pcms_pkg::SLOPE_OW-1:0]      slope_v,
	output logic signed [pcms_pkg::SLOPE_OW-1:0]      slope_w,
	output logic [pcms_pkg::BUS_OW-1:0]               bus_voltage
);
	import pcms_pkg::*;

	localparam int NW      = $clog2(MAX_WINDOW + 1);
	localparam int MEAN_W  = SAMPLE_BITS + NW;
	localparam int SLOPE_W = SAMPLE_BITS + 2 * NW;
	localparam int BUS_W   = SAMPLE_BITS + NW;
	localparam int PSS_W   = 3 * NW;
	localparam int PW      = NW + 2;
	localparam int DV      = PSS_W;

	logic [WLEN_W-1:0] window_len_q;
	logic [GAIN_W-1:0] current_gain_q, vbus_gain_q, sample_rate_q;

	logic [NW-1:0]              count_q;
	logic signed [MEAN_W-1:0]   mean_q  [3];
	logic signed [SLOPE_W-1:0]  slope_q [3];
	logic [BUS_W-1:0]           bus_sum_q;
	logic [PSS_W-1:0]           pss_q;

	logic [DW-1:0]    prod_q, mcand_q;
	logic [MPL_W-1:0] mplier_q;
	logic [DV-1:0]    rem_q;

	logic signed [CUR_OW-1:0]   cur_q [3];
	logic signed [SLOPE_OW-1:0] slp_q [3];
	logic [BUS_OW-1:0]          bus_out_q;

	logic [NW-1:0]                  n_eff;
	logic signed [PW-1:0]           pos;
	logic [SAMPLE_BITS-1:0]         ph_raw [3];
	logic signed [SAMPLE_BITS:0]    dph    [3];
	logic signed [SAMPLE_BITS+PW:0] dprod  [3];
	logic signed [2*PW-1:0]         sq;
	logic                           wlen_write;
	logic                           clear_all;

	logic [PROD1_W-1:0] src_mag;
	logic               src_pos;
	logic [GAIN_W-1:0]  gain_sel;
	logic [DV-1:0]      divisor;
	logic [DV:0]        rem_sh;
	logic               round_up;
	logic [DW:0]        qr;
	logic [SLOPE_OW-1:0] sat_cur, sat_slp;
	logic [BUS_OW-1:0]  sat_bus;

	function automatic logic [PROD1_W-1:0] mag_mean(input logic signed [MEAN_W-1:0] v);
		logic [MEAN_W-1:0] m;
		m = v[MEAN_W-1] ? $unsigned(-v) : $unsigned(v);
		return PROD1_W'(m);
	endfunction

	function automatic logic [PROD1_W-1:0] mag_slope(input logic signed [SLOPE_W-1:0] v);
		logic [SLOPE_W-1:0] m;
		m = v[SLOPE_W-1] ? $unsigned(-v) : $unsigned(v);
		return PROD1_W'(m);
	endfunction

	function automatic logic [SLOPE_OW-1:0] sat_neg(input logic [DW:0] q, input logic sp,
			input int unsigned bits);
		logic [DW:0] half;
		logic [DW:0] m;
		half = (DW + 1)'(1) << (bits - 1);
		if (sp) begin
			m = (q > half) ? half : q;
			m = (DW + 1)'(0) - m;
		end else begin
			m = (q > half - (DW + 1)'(1)) ? half - (DW + 1)'(1) : q;
		end
		return m[SLOPE_OW-1:0];
	endfunction

	assign ph_raw[0] = u_raw;
	assign ph_raw[1] = v_raw;
	assign ph_raw[2] = w_raw;

	always_comb begin
		if (window_len_q < WLEN_W'(2)) begin
			n_eff = NW'(2);
		end else if (32'(window_len_q) > 32'(MAX_WINDOW)) begin
			n_eff = NW'(MAX_WINDOW);
		end else begin
			n_eff = NW'(window_len_q);
		end
	end

	assign pos = $signed({1'b0, count_q, 1'b0}) - $signed({2'b00, n_eff}) + $signed(PW'(1));
	assign sq  = pos * pos;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dph[i]   = $signed({1'b0, ph_raw[i]})
				- $signed({2'b01, {(SAMPLE_BITS - 1){1'b0}}});
			dprod[i] = dph[i] * pos;
		end
	end

	assign sts.last   = (({1'b0, count_q} + (NW + 1)'(1)) == {1'b0, n_eff});
	assign wlen_write = cfg_we && (reg_idx_t'(cfg_index) == REG_WINDOW_LEN);
	assign clear_all  = cmd.clear || wlen_write;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q   <= WLEN_RST;
			current_gain_q <= GAIN_RST;
			vbus_gain_q    <= GAIN_RST;
			sample_rate_q  <= RATE_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_WINDOW_LEN:   window_len_q   <= cfg_data[WLEN_W-1:0];
				REG_CURRENT_GAIN: current_gain_q <= cfg_data[GAIN_W-1:0];
				REG_VBUS_GAIN:    vbus_gain_q    <= cfg_data[GAIN_W-1:0];
				REG_SAMPLE_RATE:  sample_rate_q  <= cfg_data[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			bus_sum_q <= '0;
			pss_q     <= '0;
			for (int i = 0; i < 3; i++) begin
				mean_q[i]  <= '0;
				slope_q[i] <= '0;
			end
		end else if (clear_all) begin
			count_q   <= '0;
			bus_sum_q <= '0;
			pss_q     <= '0;
			for (int i = 0; i < 3; i++) begin
				mean_q[i]  <= '0;
				slope_q[i] <= '0;
			end
		end else if (cmd.acc) begin
			count_q   <= count_q + NW'(1);
			bus_sum_q <= bus_sum_q + BUS_W'(bus_raw);
			pss_q     <= pss_q + PSS_W'($unsigned(sq));
			for (int i = 0; i < 3; i++) begin
				mean_q[i]  <= mean_q[i] + MEAN_W'(dph[i]);
				slope_q[i] <= slope_q[i] + SLOPE_W'(dprod[i]);
			end
		end
	end

	always_comb begin
		src_mag  = '0;
		src_pos  = 1'b0;
		gain_sel = current_gain_q;
		divisor  = DV'(n_eff);
		case (cmd.job)
			JOB_CUR_U, JOB_CUR_V, JOB_CUR_W: begin
				src_mag = mag_mean(mean_q[cmd.job[1:0]]);
				src_pos = !mean_q[cmd.job[1:0]][MEAN_W-1] && (mean_q[cmd.job[1:0]] != '0);
			end
			JOB_SLP_U: begin
				src_mag = mag_slope(slope_q[0]);
				src_pos = !slope_q[0][SLOPE_W-1] && (slope_q[0] != '0);
				divisor = pss_q;
			end
			JOB_SLP_V: begin
				src_mag = mag_slope(slope_q[1]);
				src_pos = !slope_q[1][SLOPE_W-1] && (slope_q[1] != '0);
				divisor = pss_q;
			end
			JOB_SLP_W: begin
				src_mag = mag_slope(slope_q[2]);
				src_pos = !slope_q[2][SLOPE_W-1] && (slope_q[2] != '0);
				divisor = pss_q;
			end
			JOB_BUS: begin
				src_mag  = PROD1_W'(bus_sum_q);
				gain_sel = vbus_gain_q;
			end
			default: begin
			end
		endcase
	end

	assign rem_sh   = {rem_q, prod_q[DW-1]};
	assign round_up = ({rem_q, 1'b0} >= {1'b0, divisor});
	assign qr       = {1'b0, prod_q} + (DW + 1)'(round_up);
	assign sat_cur  = sat_neg(qr, src_pos, CUR_OW);
	assign sat_slp  = sat_neg(qr, src_pos, SLOPE_OW);
	assign sat_bus  = (qr > (DW + 1)'({BUS_OW{1'b1}})) ? '1 : qr[BUS_OW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.mul_load) begin
			mcand_q  <= DW'(src_mag);
			mplier_q <= MPL_W'(gain_sel);
			prod_q   <= '0;
			rem_q    <= '0;
		end else if (cmd.mul2_load) begin
			mcand_q  <= DW'(prod_q[PROD1_W-1:0]);
			mplier_q <= {sample_rate_q, 1'b0};
			prod_q   <= '0;
		end else if (cmd.mul_step) begin
			if (mplier_q[0]) begin
				prod_q <= prod_q + mcand_q;
			end
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end else if (cmd.div_step) begin
			if (rem_sh >= {1'b0, divisor}) begin
				rem_q  <= DV'(rem_sh - {1'b0, divisor});
				prod_q <= {prod_q[DW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[DV-1:0];
				prod_q <= {prod_q[DW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			case (cmd.job)
				JOB_CUR_U: cur_q[0] <= sat_cur[CUR_OW-1:0];
				JOB_CUR_V: cur_q[1] <= sat_cur[CUR_OW-1:0];
				JOB_CUR_W: cur_q[2] <= sat_cur[CUR_OW-1:0];
				JOB_SLP_U: slp_q[0] <= sat_slp;
				JOB_SLP_V: slp_q[1] <= sat_slp;
				JOB_SLP_W: slp_q[2] <= sat_slp;
				JOB_BUS:   bus_out_q <= sat_bus;
				default: begin
				end
			endcase
		end
	end

	assign current_u   = cur_q[0];
	assign current_v   = cur_q[1];
	assign current_w   = cur_q[2];
	assign slope_u     = slp_q[0];
	assign slope_v     = slp_q[1];
	assign slope_w     = slp_q[2];
	assign bus_voltage = bus_out_q;

endmodule

`default_nettype wire

>>> rtl/phase_current_mean_slope_unit.sv
// Each sample set is taken while the unit is idle and added to the window sums.
// The set that closes a window starts a result sequence: ten
// shift-add multiplies and seven 89-step restoring divisions on one shared unit.
// A closed window waits for a pending result to be taken before it starts.
// Reset is asynchronous and active low; it restores the register defaults
// and clears all window sums.
`default_nettype none

module phase_current_mean_slope_unit #(
	parameter int unsigned MAX_WINDOW  = pcms_pkg::DEF_MAX_WINDOW,
	parameter int unsigned SAMPLE_BITS = pcms_pkg::DEF_SAMPLE_BITS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [pcms_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pcms_pkg::CFG_W-1:0]      cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [SAMPLE_BITS-1:0]          u_raw,
	input  wire logic [SAMPLE_BITS-1:0]          v_raw,
	input  wire logic [SAMPLE_BITS-1:0]          w_raw,
	input  wire logic [SAMPLE_BITS-1:0]          bus_raw,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic signed [pcms_pkg::CUR_OW-1:0]   current_u,
	output logic signed [pcms_pkg::CUR_OW-1:0]   current_v,
	output logic signed [pcms_pkg::CUR_OW-1:0]   current_w,
	output logic signed [pcms_pkg::SLOPE_OW-1:0] slope_u,
	output logic signed [pcms_pkg::SLOPE_OW-1:0] slope_v,
	output logic signed [pcms_pkg::SLOPE_OW-1:0] slope_w,
	output logic [pcms_pkg::BUS_OW-1:0]          bus_voltage
);
	import pcms_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pcms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	pcms_dpath #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.u_raw       (u_raw),
		.v_raw       (v_raw),
		.w_raw       (w_raw),
		.bus_raw     (bus_raw),
		.cmd         (cmd),
		.sts         (sts),
		.current_u   (current_u),
		.current_v   (current_v),
		.current_w   (current_w),
		.slope_u     (slope_u),
		.slope_v     (slope_v),
		.slope_w     (slope_w),
		.bus_voltage (bus_voltage)
	);

endmodule

`default_nettype wire

>>> rtl/pcms_check.sv
`default_nettype none

module pcms_check (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] current_u,
	input wire logic [31:0] bus_voltage
);

	// A waiting result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result withdrawn while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(current_u) && $stable(bus_voltage))
		else $error("result changed while stalled");

	// A new result needs a full computation sequence, so it never follows at once.
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid)
		else $error("result offered again right after it was taken");

	// Results appear only at the end of a sequence during which input requests stall.
	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a computation sequence");

endmodule

bind phase_current_mean_slope_unit pcms_check u_pcms_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.current_u   (current_u),
	.bus_voltage (bus_voltage)
);

`default_nettype wire
